FILE: hdl/lge_pkg.sv
// shared types and constants for the life grid engine
`default_nettype none

package lge_pkg;

  // action codes of an input beat
  localparam logic [1:0] ACT_TOGGLE = 2'd0;
  localparam logic [1:0] ACT_STEP   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  // reset value of both grid dimensions
  localparam logic [CFG_W-1:0] GRID_DIM_RST = 7'd64;

  // payload widths fixed by the interface
  localparam int ROW_BITS_W = 64;
  localparam int GEN_W      = 32;

  // B3/S23 neighbour counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // three-row window of one column
  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } win_t;

  // control shared by every cell of the chain
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/lge_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module lge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lge_cell.sv
// one column cell: holds a three-row window and applies the B3/S23 rule
`default_nettype none

module lge_cell (
  input  wire logic              clk,
  input  wire lge_pkg::cell_ctl_t ctl,
  input  wire logic              bit_in,
  input  wire logic              col_en,
  input  wire lge_pkg::win_t     left,
  input  wire lge_pkg::win_t     right,
  output      lge_pkg::win_t     win,
  output      logic              next_bit
);

  import lge_pkg::*;

  win_t       win_r;
  logic [3:0] ncount;

  // window shifts down by one row per beat of the sweep
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      win_r <= '0;
    end else if (ctl.shift) begin
      win_r.up  <= win_r.mid;
      win_r.mid <= win_r.dn;
      win_r.dn  <= bit_in;
    end
  end

  // live neighbours from this column and both adjacent cells
  assign ncount = 4'(left.up) + 4'(left.mid) + 4'(left.dn)
                + 4'(win_r.up) + 4'(win_r.dn)
                + 4'(right.up) + 4'(right.mid) + 4'(right.dn);

  assign next_bit = col_en &
                    ((ncount == BIRTH_COUNT) || (win_r.mid && (ncount == SURVIVE_COUNT)));
  assign win      = win_r;

endmodule

`default_nettype wire

FILE: hdl/life_grid_engine_unit.sv
// Life grid engine: a B3/S23 cell grid of MAX_COLS columns by MAX_ROWS rows,
// held one row per word in a ram. Each input beat toggles a cell, steps one
// generation or reads a row, and yields exactly one output beat with the
// addressed row, the addressed cell and the generation count. After reset the
// block writes zero to every ram row before it takes its first beat. A toggle
// or read passes through ram read (S_FETCH), update (S_DATA) and result
// (S_DONE), where the output register is loaded, and the next beat is taken
// when the block is back in S_IDLE. A step runs S_STEP before those states:
// a chain of MAX_COLS column cells sweeps every stored row once through a
// three-row window, one ram read and one ram write per cycle, then the
// addressed row is read back. While the output register still holds a stalled
// beat the block waits in S_DONE. Cells outside grid_width by
// grid_height count as dead, and a step clears every stored cell outside that
// area.
`default_nettype none

module life_grid_engine_unit #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [1:0]                       in_action,
  input  wire logic [5:0]                       in_col,
  input  wire logic [5:0]                       in_row,
  // result channel
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic [lge_pkg::ROW_BITS_W-1:0]   out_row_bits,
  output      logic                             out_cell_alive,
  output      logic [lge_pkg::GEN_W-1:0]        out_generation,
  // configuration channel
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [lge_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lge_pkg::CFG_W-1:0]        cfg_wdata
);

  import lge_pkg::*;

  localparam int AW    = $clog2(MAX_ROWS);
  localparam int CNT_W = $clog2(MAX_ROWS + 3);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W + 1 : CFG_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STEP,
    S_FETCH,
    S_DATA,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [1:0]           action_r;
  logic [5:0]           col_r;
  logic [5:0]           row_r;
  logic [GEN_W-1:0]     gen_r;
  logic [MAX_COLS-1:0]  res_bits_r;
  logic                 out_valid_r;
  logic [MAX_COLS-1:0]  out_bits_r;
  logic                 out_alive_r;
  logic [GEN_W-1:0]     out_gen_r;
  logic [CFG_W-1:0]     grid_width_r;
  logic [CFG_W-1:0]     grid_height_r;

  logic [CFG_W-1:0]      w_eff;
  logic [CMP_W-1:0]      h_eff;
  logic [MAX_COLS-1:0]   col_mask;
  logic [CMP_W-1:0]      row_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      rd_row_ext;
  logic [CMP_W-1:0]      wr_row_ext;
  logic                  row_in_area;
  logic                  col_in_area;
  logic                  tog_en;
  logic                  step_wr;
  logic [MAX_COLS-1:0]   ram_rdata;
  logic [MAX_COLS-1:0]   ram_dout_m;
  logic [MAX_COLS-1:0]   shift_row;
  logic [MAX_COLS-1:0]   next_vec;
  logic [MAX_COLS-1:0]   step_data;
  logic [MAX_COLS-1:0]   new_row;
  logic [MAX_COLS-1:0]   result_bits;
  logic [ROW_BITS_W-1:0] res_ext;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [MAX_COLS-1:0]   ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  cell_ctl_t             cell_ctl;
  win_t                  win [MAX_COLS];

  // area in use, clamped to the stored grid
  assign w_eff = (grid_width_r > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : grid_width_r;
  assign h_eff = (CMP_W'(grid_height_r) > CMP_W'(MAX_ROWS)) ?
                 CMP_W'(MAX_ROWS) : CMP_W'(grid_height_r);

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_mask
    assign col_mask[j] = (CFG_W'(j) < w_eff);
  end

  assign row_ext     = CMP_W'(row_r);
  assign cnt_ext     = CMP_W'(cnt_r);
  assign rd_row_ext  = cnt_ext - CMP_W'(1);
  assign wr_row_ext  = cnt_ext - CMP_W'(3);
  assign row_in_area = (row_ext < h_eff);
  assign col_in_area = ({1'b0, col_r} < w_eff);

  // row entering the window: the row read last cycle, dead past the area
  assign ram_dout_m = ram_rdata & col_mask;
  assign shift_row  = ((cnt_r != '0) && (rd_row_ext < h_eff)) ? ram_dout_m : '0;

  // chain of column cells
  assign cell_ctl.clear = (state_r == S_IDLE);
  assign cell_ctl.shift = (state_r == S_STEP);

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
    win_t left_w;
    win_t right_w;
    if (j == 0) begin : g_left_edge
      assign left_w = '0;
    end else begin : g_left
      assign left_w = win[j-1];
    end
    if (j == MAX_COLS - 1) begin : g_right_edge
      assign right_w = '0;
    end else begin : g_right
      assign right_w = win[j+1];
    end
    lge_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .bit_in   (shift_row[j]),
      .col_en   (col_mask[j]),
      .left     (left_w),
      .right    (right_w),
      .win      (win[j]),
      .next_bit (next_vec[j])
    );
  end

  // next-generation row, rows past the area forced dead
  assign step_wr   = (state_r == S_STEP) && (cnt_r >= CNT_W'(3));
  assign step_data = (wr_row_ext < h_eff) ? next_vec : '0;

  // toggle and read path
  assign tog_en      = (state_r == S_DATA) && (action_r == ACT_TOGGLE) &&
                       row_in_area && col_in_area;
  assign new_row     = tog_en ? (ram_rdata ^ (MAX_COLS'(1) << col_r)) : ram_rdata;
  assign result_bits = row_in_area ? (new_row & col_mask) : '0;
  assign res_ext     = ROW_BITS_W'(res_bits_r);

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row_ext[AW-1:0];
    ram_wdata = new_row;
    ram_re    = 1'b0;
    ram_raddr = row_ext[AW-1:0];
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = '0;
      end
      S_STEP: begin
        ram_we    = step_wr;
        ram_waddr = wr_row_ext[AW-1:0];
        ram_wdata = step_data;
        ram_re    = (cnt_r < CNT_W'(MAX_ROWS));
        ram_raddr = cnt_r[AW-1:0];
      end
      S_FETCH: begin
        ram_re = 1'b1;
      end
      S_DATA: begin
        ram_we = tog_en;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lge_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      cnt_r         <= '0;
      gen_r         <= '0;
      out_valid_r   <= 1'b0;
      grid_width_r  <= GRID_DIM_RST;
      grid_height_r <= GRID_DIM_RST;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_IDX_WIDTH) begin
          grid_width_r <= cfg_wdata;
        end else if (cfg_index == CFG_IDX_HEIGHT) begin
          grid_height_r <= cfg_wdata;
        end
      end

      // drop a taken output beat unless the next one loads now
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          if (cnt_r == CNT_W'(MAX_ROWS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            action_r <= in_action;
            col_r    <= in_col;
            row_r    <= in_row;
            cnt_r    <= '0;
            state_r  <= (in_action == ACT_STEP) ? S_STEP : S_FETCH;
          end
        end
        S_STEP: begin
          if (cnt_r == CNT_W'(MAX_ROWS + 2)) begin
            gen_r   <= gen_r + GEN_W'(1);
            state_r <= S_FETCH;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_FETCH: begin
          state_r <= S_DATA;
        end
        S_DATA: begin
          res_bits_r <= result_bits;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_bits_r  <= res_bits_r;
            out_alive_r <= res_ext[col_r];
            out_gen_r   <= gen_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_row_bits   = ROW_BITS_W'(out_bits_r);
  assign out_cell_alive = out_alive_r;
  assign out_generation = out_gen_r;

endmodule

`default_nettype wire

FILE: sim/tb.sv
// self-checking testbench for the life grid engine: directed edge cases, then random traffic
`timescale 1ns / 100ps

module tb;
  import lge_pkg::*;

  // spare action code, decoded as a read
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int GRID_COLS   = 64;
  localparam int GRID_ROWS   = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam int REPORT_CAP  = 40;
  localparam int PHASE_ITEMS = 97;

  // what one result beat carries
  typedef struct packed {
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  cell_alive;
    logic [GEN_W-1:0]      generation;
  } row_view_t;

  // dut ports
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_action = ACT_READ;
  logic [5:0]            in_col    = '0;
  logic [5:0]            in_row    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ROW_BITS_W-1:0] out_row_bits;
  logic                  out_cell_alive;
  logic [GEN_W-1:0]      out_generation;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IDX_WIDTH;
  logic [CFG_W-1:0]      cfg_wdata = GRID_DIM_RST;

  // grid model and its settings
  logic [63:0]     grid_model [GRID_ROWS];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [GEN_W-1:0] gen_model;
  row_view_t       expected_views [$];
  row_view_t       want_view;

  // traffic shaping and bookkeeping
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int items_sent     = 0;
  int toggles_sent   = 0;
  int steps_sent     = 0;
  int reads_sent     = 0;
  int results_seen   = 0;
  int settings_used  = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  life_grid_engine_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_col         (in_col),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_bits   (out_row_bits),
    .out_cell_alive (out_cell_alive),
    .out_generation (out_generation),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // area in use, clipped to the physical grid
  function automatic int cols_in_use();
    return (width_reg > GRID_COLS) ? GRID_COLS : int'(width_reg);
  endfunction

  function automatic int rows_in_use();
    return (height_reg > GRID_ROWS) ? GRID_ROWS : int'(height_reg);
  endfunction

  function automatic logic [63:0] live_mask();
    int w;
    w = cols_in_use();
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  // one B3/S23 generation, cells outside the area count as dead and are cleared
  function automatic void advance_generation();
    logic [63:0] m;
    logic [63:0] up;
    logic [63:0] mid;
    logic [63:0] dn;
    logic [63:0] nxt;
    logic [63:0] nbr [8];
    logic [63:0] fresh [GRID_ROWS];
    int h;
    int cnt;
    h = rows_in_use();
    m = live_mask();
    foreach (fresh[r]) fresh[r] = '0;
    for (int r = 0; r < h; r++) begin
      up  = (r > 0) ? (grid_model[r-1] & m) : '0;
      mid = grid_model[r] & m;
      dn  = (r + 1 < h) ? (grid_model[r+1] & m) : '0;
      nbr[0] = (up << 1) & m;
      nbr[1] = up;
      nbr[2] = (up >> 1) & m;
      nbr[3] = (mid << 1) & m;
      nbr[4] = (mid >> 1) & m;
      nbr[5] = (dn << 1) & m;
      nbr[6] = dn;
      nbr[7] = (dn >> 1) & m;
      nxt = '0;
      for (int c = 0; c < 64; c++) begin
        cnt = 0;
        for (int k = 0; k < 8; k++) cnt += nbr[k][c];
        if (cnt == BIRTH_COUNT || (mid[c] && cnt == SURVIVE_COUNT)) nxt[c] = 1'b1;
      end
      fresh[r] = nxt & m;
    end
    grid_model = fresh;
    gen_model  = gen_model + 1'b1;
  endfunction

  // apply one accepted action to the model and return the result it yields
  function automatic row_view_t apply_action(logic [1:0] act, logic [5:0] col, logic [5:0] row);
    row_view_t   v;
    logic [63:0] bits;
    if (act == ACT_TOGGLE) begin
      if (col < cols_in_use() && row < rows_in_use())
        grid_model[row][col] = ~grid_model[row][col];
    end else if (act == ACT_STEP) begin
      advance_generation();
    end
    bits = (row < rows_in_use()) ? (grid_model[row] & live_mask()) : '0;
    v.row_bits   = bits;
    v.cell_alive = bits[col];
    v.generation = gen_model;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // send one input beat, predict its result once accepted
  task automatic send_item(input logic [1:0] act, input logic [5:0] col, input logic [5:0] row);
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_col    <= col;
    in_row    <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_views.push_back(apply_action(act, col, row));
    items_sent++;
    case (act)
      ACT_TOGGLE: toggles_sent++;
      ACT_STEP:   steps_sent++;
      default:    reads_sent++;
    endcase
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
  endtask

  // one register write beat; valid is lowered by the next input beat
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_IDX_WIDTH) width_reg = val;
    else if (idx == CFG_IDX_HEIGHT) height_reg = val;
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    drain_results();
    write_register(CFG_IDX_WIDTH, w);
    write_register(CFG_IDX_HEIGHT, h);
    settings_used++;
  endtask

  // drop a small shape, then evolve it a few generations and look at it
  task automatic grow_pattern();
    int          oc;
    int          orow;
    logic [15:0] shape;
    oc   = $urandom_range(0, (cols_in_use() > 4) ? cols_in_use() - 4 : 3);
    orow = $urandom_range(0, (rows_in_use() > 4) ? rows_in_use() - 4 : 3);
    case ($urandom_range(0, 3))
      0:       shape = 16'h0742;  // glider
      1:       shape = 16'h0007;  // blinker
      2:       shape = 16'h0033;  // block
      default: shape = 16'($urandom);
    endcase
    for (int i = 0; i < 16; i++)
      if (shape[i]) send_item(ACT_TOGGLE, 6'(oc + i % 4), 6'(orow + i / 4));
    repeat ($urandom_range(1, 4)) begin
      send_item(ACT_STEP, 6'(oc + $urandom_range(0, 3)), 6'(orow + $urandom_range(0, 3)));
      send_item(($urandom_range(0, 7) == 0) ? ACT_SPARE : ACT_READ,
                6'(oc + $urandom_range(0, 3)), 6'(orow + $urandom_range(0, 3)));
    end
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                  input int idle_pct, input int hold_pct, input int count);
    int target;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    set_grid(w, h);
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 70)
        grow_pattern();
      else
        send_item(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom));
    end
  endtask

  // corners of the full grid, lone cells dying, blinker on the top edge
  task automatic test_corner_cells();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_grid(7'd64, 7'd64);
    send_item(ACT_TOGGLE, 6'd0, 6'd0);
    send_item(ACT_TOGGLE, 6'd63, 6'd0);
    send_item(ACT_TOGGLE, 6'd0, 6'd63);
    send_item(ACT_TOGGLE, 6'd63, 6'd63);
    send_item(ACT_READ, 6'd63, 6'd63);
    send_item(ACT_SPARE, 6'd0, 6'd0);
    send_item(ACT_STEP, 6'd63, 6'd0);
    send_item(ACT_TOGGLE, 6'd30, 6'd0);
    send_item(ACT_TOGGLE, 6'd31, 6'd0);
    send_item(ACT_TOGGLE, 6'd32, 6'd0);
    send_item(ACT_STEP, 6'd31, 6'd1);
    send_item(ACT_READ, 6'd31, 6'd0);
  endtask

  // no cell in use: toggles ignored, reads empty, a step clears and counts
  task automatic test_zero_area();
    send_idle_pct = 30;
    stall_pct     = 30;
    set_grid(7'd0, 7'd0);
    send_item(ACT_TOGGLE, 6'd5, 6'd5);
    send_item(ACT_READ, 6'd5, 6'd5);
    send_item(ACT_STEP, 6'd5, 6'd5);
    send_item(ACT_SPARE, 6'd0, 6'd0);
  endtask

  // stored cells outside a shrunken area are hidden, then wiped by a step
  task automatic test_outside_area();
    send_idle_pct = 0;
    stall_pct     = 30;
    set_grid(7'd64, 7'd64);
    send_item(ACT_TOGGLE, 6'd10, 6'd2);
    send_item(ACT_TOGGLE, 6'd2, 6'd20);
    set_grid(7'd5, 7'd7);
    send_item(ACT_READ, 6'd10, 6'd2);
    send_item(ACT_READ, 6'd2, 6'd20);
    send_item(ACT_TOGGLE, 6'd10, 6'd2);
    send_item(ACT_STEP, 6'd2, 6'd2);
    set_grid(7'd127, 7'd127);
    send_item(ACT_READ, 6'd10, 6'd2);
    send_item(ACT_READ, 6'd2, 6'd20);
  endtask

  // random traffic over several grid shapes and idle patterns
  task automatic test_random_traffic();
    run_random_phase(7'd64, 7'd64, 0, 0, PHASE_ITEMS);
    run_random_phase(7'd8, 7'd6, 67, 0, PHASE_ITEMS);
    run_random_phase(7'd1, 7'd1, 0, 67, PHASE_ITEMS);
    run_random_phase(7'd127, 7'd100, 19, 19, PHASE_ITEMS);
    run_random_phase(7'd16, 7'd16, 0, 0, PHASE_ITEMS);
    run_random_phase(7'd0, 7'd5, 67, 0, PHASE_ITEMS);
    run_random_phase(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 0, 67,
                     PHASE_ITEMS);
    run_random_phase(7'd64, 7'd3, 19, 19, PHASE_ITEMS);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_views.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_row_bits, '0);
      end else begin
        want_view = expected_views.pop_front();
        if (out_row_bits !== want_view.row_bits)
          report_mismatch("row_bits", out_row_bits, want_view.row_bits);
        if (out_cell_alive !== want_view.cell_alive)
          report_mismatch("cell_alive", 64'(out_cell_alive), 64'(want_view.cell_alive));
        if (out_generation !== want_view.generation)
          report_mismatch("generation", 64'(out_generation), 64'(want_view.generation));
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // test sequence
  initial begin
    width_reg  = GRID_DIM_RST;
    height_reg = GRID_DIM_RST;
    gen_model  = '0;
    foreach (grid_model[r]) grid_model[r] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_cells();
    test_zero_area();
    test_outside_area();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_views.size() != 0)
      report_mismatch("results never delivered", 64'(expected_views.size()), '0);

    $display("covered %0d input beats (%0d toggles, %0d steps, %0d reads) over %0d grid shapes",
             items_sent, toggles_sent, steps_sent, reads_sent, settings_used);
    $display("checked %0d result beats, %0d mismatches, last generation %0d",
             results_seen, mismatch_count, gen_model);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/lge_pkg.sv
hdl/lge_ram.sv
hdl/lge_cell.sv
hdl/life_grid_engine_unit.sv
sim/tb.sv
